FILE: sv/att_pkg.sv
package att_pkg;

  localparam logic [4:0] K_EOF   = 5'd0;
  localparam logic [4:0] K_UNDEF = 5'd1;
  localparam logic [4:0] K_NAME  = 5'd2;
  localparam logic [4:0] K_INT   = 5'd3;
  localparam logic [4:0] K_PUNCT0 = 5'd4;
  localparam logic [4:0] K_KEY0  = 5'd14;
  localparam logic [4:0] K_LONG  = 5'd26;

  localparam logic [62:0] NUM_MAX = {63{1'b1}};
  // Wide enough for a name length or index up to 63, which covers the default buffer size of 32.
  localparam int LEN_W = 6;
  localparam int NUM_KEYS = 12;
  localparam int NUM_PUNCT = 10;

  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;

  localparam logic [7:0] PUNCT [NUM_PUNCT] = '{8'h28, 8'h29, 8'h3D, 8'h3A, 8'h2C,
                                               8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h25};

  localparam logic [55:0] KEY_STR [NUM_KEYS] = '{"proc", "endproc", "cmp", "jmp", "je",
                                                 "jne", "jl", "jle", "jg", "jge",
                                                 "call", "ret"};
  localparam int KEY_LEN [NUM_KEYS] = '{4, 7, 3, 3, 2, 3, 2, 3, 2, 3, 4, 3};

  typedef enum logic [2:0] {
    MODE_IDLE, MODE_COMMENT, MODE_NUMBER, MODE_NAME, MODE_HALT
  } mode_t;

  typedef enum logic [1:0] {
    OP_TOKEN, OP_WRITE, OP_RUN
  } op_t;

  // One queued command from the scanner to the emitter.
  typedef struct packed {
    op_t              op;
    logic [4:0]       kind;
    logic [62:0]      num;
    logic [31:0]      line;
    logic [31:0]      col;
    logic [7:0]       wbyte;
    logic [LEN_W-1:0] idx;       // write index, or run length
    logic             item_last;
  } cmd_t;

  function automatic logic [7:0] key_char(input logic [3:0] i, input logic [2:0] p);
    logic [55:0] s;
    int sh;
    s = KEY_STR[i];
    if (int'(p) >= KEY_LEN[i]) return 8'h00;
    sh = 8 * (KEY_LEN[i] - 1 - int'(p));
    return s[sh +: 8];
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_first(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) || c == CH_DOT ||
           c == CH_UNDER || c == CH_BANG || c == CH_AT || c == CH_HASH || c == CH_DOLLAR;
  endfunction

  function automatic cmd_t mk_cmd(input op_t op, input logic [4:0] kind,
                                  input logic [62:0] num, input logic [31:0] line,
                                  input logic [31:0] col, input logic [7:0] b,
                                  input logic [LEN_W-1:0] idx);
    cmd_t c;
    c.op = op;
    c.kind = kind;
    c.num = num;
    c.line = line;
    c.col = col;
    c.wbyte = b;
    c.idx = idx;
    c.item_last = 1'b0;
    return c;
  endfunction

endpackage

FILE: sv/att_front.sv
module att_front #(
  parameter int NAME_MAX = 32
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [7:0]     in_byte,
  input  logic           in_end,
  output logic           q_valid,
  input  logic           q_ready,
  output att_pkg::cmd_t  q_cmd
);
  import att_pkg::*;

  localparam int LW = $clog2(NAME_MAX + 1);

  mode_t           mode_r, mode_nxt;
  logic [62:0]     acc_r, acc_nxt;
  logic [LW-1:0]   len_r, len_nxt;
  logic [NUM_KEYS-1:0] kwm_r, kwm_nxt;
  logic [31:0]     line_r, line_nxt, col_r, col_nxt;
  logic [31:0]     sline_r, sline_nxt, scol_r, scol_nxt;
  logic            pend_valid_r, pend_valid_nxt;
  cmd_t            pend_r, pend_nxt;

  logic            fire;
  logic [66:0]     prod;
  logic [31:0]     adv_line, adv_col;
  logic            kw_hit;
  logic [3:0]      kw_idx;
  cmd_t            fc;

  assign in_ready = !pend_valid_r && q_ready;
  assign fire = in_valid && in_ready;
  assign adv_line = (in_byte == CH_NL) ? line_r + 32'd1 : line_r;
  assign adv_col  = (in_byte == CH_NL) ? 32'd1 : col_r + 32'd1;
  assign prod = 67'({acc_r, 3'b000}) + 67'({acc_r, 1'b0}) + 67'(in_byte - 8'h30);

  always_comb begin
    kw_hit = 1'b0;
    kw_idx = '0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (kwm_r[i] && len_r == LW'(KEY_LEN[i])) begin
        kw_hit = 1'b1;
        kw_idx = 4'(i);
      end
    end
    if (mode_r == MODE_NUMBER)
      fc = mk_cmd(OP_TOKEN, K_INT, acc_r, sline_r, scol_r, 8'h00, '0);
    else if (kw_hit)
      fc = mk_cmd(OP_TOKEN, K_KEY0 + 5'(kw_idx), '0, sline_r, scol_r, 8'h00, '0);
    else
      fc = mk_cmd(OP_RUN, K_NAME, '0, sline_r, scol_r, 8'h00, LEN_W'(len_r));
  end

  always_comb begin
    logic f_v, s_v, do_idle, s_out, found;
    cmd_t f, s;
    logic [4:0] pk;
    mode_nxt = mode_r;
    acc_nxt = acc_r;
    len_nxt = len_r;
    kwm_nxt = kwm_r;
    line_nxt = line_r;
    col_nxt = col_r;
    sline_nxt = sline_r;
    scol_nxt = scol_r;
    f_v = 1'b0;
    s_v = 1'b0;
    do_idle = 1'b0;
    found = 1'b0;
    pk = '0;
    f = fc;
    s = fc;
    if (fire) begin
      if (in_end) begin
        f_v = (mode_r == MODE_NUMBER) || (mode_r == MODE_NAME);
        s_v = 1'b1;
        s = mk_cmd(OP_TOKEN, K_EOF, '0, line_r, col_r, 8'h00, '0);
        mode_nxt = MODE_IDLE;
        acc_nxt = '0;
        len_nxt = '0;
        line_nxt = 32'd1;
        col_nxt = 32'd1;
        sline_nxt = 32'd1;
        scol_nxt = 32'd1;
      end else begin
        unique case (mode_r)
          MODE_HALT: ;
          MODE_COMMENT: begin
            line_nxt = adv_line;
            col_nxt = adv_col;
            if (in_byte == CH_NL) mode_nxt = MODE_IDLE;
          end
          MODE_NUMBER: begin
            if (is_digit(in_byte)) begin
              acc_nxt = (|prod[66:63]) ? NUM_MAX : prod[62:0];
              line_nxt = adv_line;
              col_nxt = adv_col;
            end else begin
              f_v = 1'b1;
              mode_nxt = MODE_IDLE;
              do_idle = 1'b1;
            end
          end
          MODE_NAME: begin
            if (is_first(in_byte) || is_digit(in_byte)) begin
              if (len_r >= LW'(NAME_MAX)) begin
                s_v = 1'b1;
                s = mk_cmd(OP_TOKEN, K_LONG, '0, sline_r, scol_r, 8'h00, '0);
                mode_nxt = MODE_HALT;
                len_nxt = '0;
              end else begin
                s_v = 1'b1;
                s = mk_cmd(OP_WRITE, K_NAME, '0, '0, '0, in_byte, LEN_W'(len_r));
                len_nxt = len_r + LW'(1);
                for (int i = 0; i < NUM_KEYS; i++)
                  kwm_nxt[i] = kwm_r[i] && (len_r < LW'(KEY_LEN[i])) &&
                               in_byte == key_char(4'(i), len_r[2:0]);
                line_nxt = adv_line;
                col_nxt = adv_col;
              end
            end else begin
              f_v = 1'b1;
              mode_nxt = MODE_IDLE;
              do_idle = 1'b1;
            end
          end
          MODE_IDLE: do_idle = 1'b1;
        endcase
        if (do_idle) begin
          if (is_blank(in_byte)) begin
            line_nxt = adv_line;
            col_nxt = adv_col;
          end else if (in_byte == CH_SEMI) begin
            line_nxt = adv_line;
            col_nxt = adv_col;
            mode_nxt = MODE_COMMENT;
          end else if (is_digit(in_byte)) begin
            sline_nxt = line_r;
            scol_nxt = col_r;
            acc_nxt = 63'(in_byte - 8'h30);
            mode_nxt = MODE_NUMBER;
            line_nxt = adv_line;
            col_nxt = adv_col;
          end else if (is_first(in_byte)) begin
            sline_nxt = line_r;
            scol_nxt = col_r;
            s_v = 1'b1;
            s = mk_cmd(OP_WRITE, K_NAME, '0, '0, '0, in_byte, '0);
            len_nxt = LW'(1);
            for (int i = 0; i < NUM_KEYS; i++)
              kwm_nxt[i] = in_byte == key_char(4'(i), 3'd0);
            mode_nxt = MODE_NAME;
            line_nxt = adv_line;
            col_nxt = adv_col;
          end else begin
            for (int i = 0; i < NUM_PUNCT; i++) begin
              if (PUNCT[i] == in_byte) begin
                found = 1'b1;
                pk = 5'(i);
              end
            end
            s_v = 1'b1;
            if (found) begin
              s = mk_cmd(OP_TOKEN, K_PUNCT0 + pk, '0, line_r, col_r, 8'h00, '0);
              line_nxt = adv_line;
              col_nxt = adv_col;
            end else begin
              s = mk_cmd(OP_TOKEN, K_UNDEF, '0, line_r, col_r, 8'h00, '0);
              mode_nxt = MODE_HALT;
            end
          end
        end
      end
    end
    // The last command that produces output carries the end-of-item mark.
    s_out = s_v && s.op == OP_TOKEN;
    s.item_last = s_out;
    f.item_last = !s_out;

    pend_nxt = pend_r;
    pend_valid_nxt = pend_valid_r;
    if (pend_valid_r) begin
      q_valid = 1'b1;
      q_cmd = pend_r;
      if (q_ready) pend_valid_nxt = 1'b0;
    end else begin
      q_valid = fire && (f_v || s_v);
      q_cmd = f_v ? f : s;
      if (f_v && s_v) begin
        pend_valid_nxt = 1'b1;
        pend_nxt = s;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      acc_r <= '0;
      len_r <= '0;
      kwm_r <= '0;
      line_r <= 32'd1;
      col_r <= 32'd1;
      sline_r <= 32'd1;
      scol_r <= 32'd1;
      pend_valid_r <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      acc_r <= acc_nxt;
      len_r <= len_nxt;
      kwm_r <= kwm_nxt;
      line_r <= line_nxt;
      col_r <= col_nxt;
      sline_r <= sline_nxt;
      scol_r <= scol_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
  end

endmodule

FILE: sv/att_queue.sv
module att_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  att_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output att_pkg::cmd_t pop_cmd
);
  import att_pkg::*;

  cmd_t       mem_r [4];
  logic [1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       do_push, do_pop;

  assign push_ready = cnt_r != 3'd4;
  assign pop_valid = cnt_r != 3'd0;
  assign pop_cmd = mem_r[rp_r];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_comb begin
    wp_nxt = do_push ? wp_r + 2'd1 : wp_r;
    rp_nxt = do_pop ? rp_r + 2'd1 : rp_r;
    cnt_nxt = cnt_r + 3'(do_push) - 3'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_cmd;
  end

endmodule

FILE: sv/att_back.sv
module att_back #(
  parameter int NAME_MAX = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_ready,
  input  att_pkg::cmd_t q_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [4:0]    out_kind,
  output logic [62:0]   out_num,
  output logic [31:0]   out_line,
  output logic [31:0]   out_col,
  output logic [7:0]    out_text,
  output logic          out_tok_last,
  output logic          out_item_last
);
  import att_pkg::*;

  localparam int LW = $clog2(NAME_MAX + 1);
  localparam int IW = $clog2(NAME_MAX);

  logic [7:0]    mem [NAME_MAX];
  logic [7:0]    rd_data_r;
  logic          have_r, have_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt;
  logic          ov_r, ov_nxt;
  logic [4:0]    kind_r, kind_nxt;
  logic [62:0]   num_r, num_nxt;
  logic [31:0]   line_r, line_nxt, col_r, col_nxt;
  logic [7:0]    text_r, text_nxt;
  logic          tl_r, tl_nxt, il_r, il_nxt;
  logic          can_load, wr_en, run_last;

  assign can_load = !ov_r || out_ready;
  assign run_last = (cnt_r + LW'(1)) == q_cmd.idx[LW-1:0];

  always_comb begin
    q_ready = 1'b0;
    wr_en = 1'b0;
    have_nxt = have_r;
    cnt_nxt = cnt_r;
    ov_nxt = ov_r && !out_ready;
    kind_nxt = kind_r;
    num_nxt = num_r;
    line_nxt = line_r;
    col_nxt = col_r;
    text_nxt = text_r;
    tl_nxt = tl_r;
    il_nxt = il_r;
    if (q_valid) begin
      unique case (q_cmd.op)
        OP_WRITE: begin
          wr_en = 1'b1;
          q_ready = 1'b1;
        end
        OP_RUN: begin
          // A byte takes two steps: a registered read of the buffer, then a load of the output.
          if (!have_r) begin
            have_nxt = 1'b1;
          end else if (can_load) begin
            have_nxt = 1'b0;
            ov_nxt = 1'b1;
            kind_nxt = K_NAME;
            num_nxt = '0;
            line_nxt = q_cmd.line;
            col_nxt = q_cmd.col;
            text_nxt = rd_data_r;
            tl_nxt = run_last;
            il_nxt = run_last && q_cmd.item_last;
            cnt_nxt = run_last ? '0 : cnt_r + LW'(1);
            q_ready = run_last;
          end
        end
        default: begin
          if (can_load) begin
            ov_nxt = 1'b1;
            kind_nxt = q_cmd.kind;
            num_nxt = q_cmd.num;
            line_nxt = q_cmd.line;
            col_nxt = q_cmd.col;
            text_nxt = 8'h00;
            tl_nxt = 1'b1;
            il_nxt = q_cmd.item_last;
            q_ready = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[q_cmd.idx[IW-1:0]] <= q_cmd.wbyte;
    rd_data_r <= mem[cnt_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      have_r <= 1'b0;
      cnt_r <= '0;
      ov_r <= 1'b0;
    end else begin
      have_r <= have_nxt;
      cnt_r <= cnt_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    num_r <= num_nxt;
    line_r <= line_nxt;
    col_r <= col_nxt;
    text_r <= text_nxt;
    tl_r <= tl_nxt;
    il_r <= il_nxt;
  end

  assign out_valid = ov_r;
  assign out_kind = kind_r;
  assign out_num = num_r;
  assign out_line = line_r;
  assign out_col = col_r;
  assign out_text = text_r;
  assign out_tok_last = tl_r;
  assign out_item_last = il_r;

endmodule

FILE: sv/assembly_text_tokenizer_core.sv
// Channel | dir | tdata (low bit up)                               | tuser        | tlast
// in_     | in  | source byte [7:0]                                | end of input | -
// out_    | out | kind, number value, line, column, text byte, pad | item last    | token last
//
// A scanner takes one byte per cycle while the queue has room; an item that yields two
// commands (a flushed token and a command for the byte itself, or EOF) holds the input
// until the second is queued. A four-entry command queue sits between scanner and emitter.
// Tokens leave one per cycle unless the output stalls; a name byte is first registered from the buffer read port.
// Reset is synchronous and clears all control state; no clearing pass is needed.
// Either side may stall at any time without loss.
module assembly_text_tokenizer_core #(
  parameter int NAME_MAX = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // in_byte
  input  logic         in_tuser,   // end_of_input
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata,  // kind, number_value, token_line, token_column, text_byte
  output logic         out_tuser,  // item_last
  output logic         out_tlast
);
  import att_pkg::*;

  logic        fq_valid, fq_ready, qb_valid, qb_ready;
  cmd_t        fq_cmd, qb_cmd;
  logic [4:0]  kind;
  logic [62:0] num;
  logic [31:0] line, col;
  logic [7:0]  text;

  att_front #(.NAME_MAX(NAME_MAX)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready), .in_byte(in_tdata), .in_end(in_tuser),
    .q_valid(fq_valid), .q_ready(fq_ready), .q_cmd(fq_cmd)
  );

  att_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push_valid(fq_valid), .push_ready(fq_ready), .push_cmd(fq_cmd),
    .pop_valid(qb_valid), .pop_ready(qb_ready), .pop_cmd(qb_cmd)
  );

  att_back #(.NAME_MAX(NAME_MAX)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(qb_valid), .q_ready(qb_ready), .q_cmd(qb_cmd),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_kind(kind), .out_num(num), .out_line(line), .out_col(col), .out_text(text),
    .out_tok_last(out_tlast), .out_item_last(out_tuser)
  );

  assign out_tdata = {4'b0000, text, col, line, num, kind};

endmodule

FILE: sv/att_checker.sv
module att_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [7:0]   in_tdata,
  input logic         in_tuser,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [143:0] out_tdata,
  input logic         out_tuser,
  input logic         out_tlast
);
  import att_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[4:0] <= K_LONG)
    else $error("kind out of range");

  a_eof: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4:0] == K_EOF |-> out_tuser && out_tlast)
    else $error("EOF beat must close token and item");

  a_num: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[67:5] != '0 |-> out_tdata[4:0] == K_INT)
    else $error("number value on a non-integer beat");

  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind assembly_text_tokenizer_core att_checker u_att_checker (.*);
